@@ src/pva_pkg.sv @@
`default_nettype none
package pva_pkg;

  localparam int PRI_W  = 32;
  localparam int MASK_W = 8;
  localparam int CHAN_W = 3;
  localparam int ADDR_W = 2;

  localparam logic [PRI_W-1:0] PRI_MAX = 32'hFFFF_FFFF;

  localparam logic REQ_PLAY    = 1'b0;
  localparam logic REQ_SILENCE = 1'b1;

  localparam logic [ADDR_W-1:0] REG_SOUND_ENABLED = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [PRI_W-1:0] pri;
  } scan_t;

  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [PRI_W-1:0] wr_data;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ src/pva_in_if.sv @@
`default_nettype none
interface pva_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [pva_pkg::PRI_W-1:0]  sound_priority;
  logic                       higher_only;
  logic                       audible;
  logic [pva_pkg::MASK_W-1:0] active_mask;

  modport source (output valid, req_type, sound_priority, higher_only, audible, active_mask,
                  input ready);
  modport sink (input valid, req_type, sound_priority, higher_only, audible, active_mask,
                output ready);
endinterface
`default_nettype wire

@@ src/pva_out_if.sv @@
`default_nettype none
interface pva_out_if;
  logic                       valid;
  logic                       ready;
  logic                       granted;
  logic [pva_pkg::CHAN_W-1:0] channel;
  logic [pva_pkg::PRI_W-1:0]  channel_priority;

  modport source (output valid, granted, channel, channel_priority, input ready);
  modport sink (input valid, granted, channel, channel_priority, output ready);
endinterface
`default_nettype wire

@@ src/pva_cell.sv @@
`default_nettype none
module pva_cell #(
  parameter int IDX_W = 3
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire pva_pkg::cell_ctrl_t   ctrl,
  input  wire                        active,
  input  wire  [IDX_W-1:0]           cell_idx,
  input  wire pva_pkg::scan_t        tok_in,
  input  wire  [IDX_W-1:0]           chan_in,
  output pva_pkg::scan_t             tok_out,
  output logic [IDX_W-1:0]           chan_out
);

  logic [pva_pkg::PRI_W-1:0] entry;
  logic [pva_pkg::PRI_W-1:0] entry_eff;
  logic                      out_valid;
  logic [pva_pkg::PRI_W-1:0] out_pri;
  logic [IDX_W-1:0]          out_chan;

  // An idle channel holds no claim on its voice.
  assign entry_eff = active ? entry : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctrl.clear) begin
      entry <= '0;
    end else if (ctrl.wr_en) begin
      entry <= ctrl.wr_data;
    end else if (tok_in.valid) begin
      entry <= entry_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      if (entry_eff < tok_in.pri) begin
        out_pri  <= entry_eff;
        out_chan <= cell_idx;
      end else begin
        out_pri  <= tok_in.pri;
        out_chan <= chan_in;
      end
    end
  end

  assign tok_out.valid = out_valid;
  assign tok_out.pri   = out_pri;
  assign chan_out      = out_chan;

endmodule
`default_nettype wire

@@ src/priority_voice_allocator.sv @@
`default_nettype none
// Voice allocator that keeps one priority per playback channel in a row of cells. A play
// word sends a scan token down the row, one cell per cycle; each cell zeroes its entry when
// its channel is idle and keeps the lowest priority seen, lowest index first on a tie. The
// request is granted when that priority is below the sound priority, or equal when
// higher_only is clear, and an audible grant writes the sound priority back to the chosen
// cell. A silence word clears every entry, and with sound_enabled low every word returns a
// zero result and changes nothing. A new word is accepted only in the idle state, after the
// scan of a play word has left the cell row and the result has been loaded into the output
// register. Each input word gives exactly one result word, held there until taken.
module priority_voice_allocator #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [pva_pkg::ADDR_W-1:0]   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  pva_in_if.sink                       req,
  pva_out_if.source                    rsp
);

  localparam int IDX_W = $clog2(NUM_CHANNELS);
  localparam int EXT_W = IDX_W + pva_pkg::CHAN_W;

  pva_pkg::state_t state;
  pva_pkg::state_t state_next;

  logic                         sound_enabled;
  logic                         in_accept;
  logic                         in_ready;
  logic                         finish;
  logic                         start;
  logic                         r_play;
  logic                         r_silence;
  logic [pva_pkg::PRI_W-1:0]    r_pri;
  logic                         r_higher;
  logic                         r_audible;
  logic [pva_pkg::MASK_W-1:0]   r_mask;

  pva_pkg::scan_t               tok  [0:NUM_CHANNELS];
  logic [IDX_W-1:0]             chan [0:NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]      act;
  pva_pkg::cell_ctrl_t          ctrl [0:NUM_CHANNELS-1];

  logic [pva_pkg::PRI_W-1:0]    best_pri;
  logic [IDX_W-1:0]             best_chan;
  logic [EXT_W-1:0]             best_chan_ext;
  logic                         grant;
  logic                         wr_hit;

  logic                         out_valid;
  logic                         out_granted;
  logic [pva_pkg::CHAN_W-1:0]   out_channel;
  logic [pva_pkg::PRI_W-1:0]    out_pri;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enabled <= 1'b1;
    end else if (psel && penable && pwrite && paddr == pva_pkg::REG_SOUND_ENABLED) begin
      sound_enabled <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == pva_pkg::REG_SOUND_ENABLED) begin
      prdata[0] = sound_enabled;
    end
  end

  assign in_accept = req.valid && in_ready;
  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pva_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    case (state)
      pva_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (req.valid) begin
          if (sound_enabled && req.req_type == pva_pkg::REQ_PLAY) begin
            state_next = pva_pkg::ST_SCAN;
          end else begin
            state_next = pva_pkg::ST_FINISH;
          end
        end
      end
      pva_pkg::ST_SCAN: begin
        if (tok[NUM_CHANNELS].valid) begin
          state_next = pva_pkg::ST_FINISH;
        end
      end
      pva_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          finish     = 1'b1;
          state_next = pva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pva_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= in_accept && sound_enabled && req.req_type == pva_pkg::REQ_PLAY;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      r_play    <= sound_enabled && req.req_type == pva_pkg::REQ_PLAY;
      r_silence <= sound_enabled && req.req_type == pva_pkg::REQ_SILENCE;
      r_pri     <= req.sound_priority;
      r_higher  <= req.higher_only;
      r_audible <= req.audible;
      r_mask    <= req.active_mask;
    end
  end

  assign tok[0].valid = start;
  assign tok[0].pri   = pva_pkg::PRI_MAX;
  assign chan[0]      = '0;

  assign best_pri      = tok[NUM_CHANNELS].pri;
  assign best_chan     = chan[NUM_CHANNELS];
  assign best_chan_ext = {{pva_pkg::CHAN_W{1'b0}}, best_chan};
  assign grant         = r_higher ? (best_pri < r_pri) : (best_pri <= r_pri);
  assign wr_hit        = finish && r_play && grant && r_audible;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    if (i < pva_pkg::MASK_W) begin : g_masked
      assign act[i] = r_mask[i];
    end else begin : g_unmasked
      assign act[i] = 1'b0;
    end

    assign ctrl[i].clear   = finish && r_silence;
    assign ctrl[i].wr_en   = wr_hit && best_chan == IDX_W'(i);
    assign ctrl[i].wr_data = r_pri;

    pva_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[i]),
      .active   (act[i]),
      .cell_idx (IDX_W'(i)),
      .tok_in   (tok[i]),
      .chan_in  (chan[i]),
      .tok_out  (tok[i+1]),
      .chan_out (chan[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_granted <= r_play && grant;
      out_channel <= r_play ? best_chan_ext[pva_pkg::CHAN_W-1:0] : '0;
      out_pri     <= r_play ? best_pri : '0;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.granted          = out_granted;
  assign rsp.channel          = out_channel;
  assign rsp.channel_priority = out_pri;

endmodule
`default_nettype wire
